### rtl/dlr_pkg.sv
// Shared types and constants for the DDA line rasteriser.
package dlr_pkg;

	// Default geometry
	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 16;

	// Input transaction action codes
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_STEP = 1'b1;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;      // capture endpoints, start both divisions
		logic div_step;  // one quotient bit per divider
		logic finish;    // turn quotients into signed increments
		logic step;      // emit one point and advance accumulators
	} dlr_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic line_active;
	} dlr_status_t;

endpackage

### rtl/dda_line_rasterizer.sv
// DDA line rasteriser top level: controller and datapath.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------
//  in      | input     | in_valid / in_stall   | action, start_x, start_y, end_x, end_y
//  out     | output    | out_valid / out_stall | point_x, point_y, last_point
//
// A step transaction on an active line yields one point; points stream at one
// per cycle while the output is not stalled, and the result register lets the
// next step enter as the previous point leaves. A load transaction occupies the
// block through both divisions (one bit per cycle from two restoring dividers)
// and the finish state. Reset clears the controller and leaves no active line.
// A stalled output holds its point and stalls the input side.
module dda_line_rasterizer import dlr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         action,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [COORD_BITS-1:0] point_x,
	output logic signed [COORD_BITS-1:0] point_y,
	output logic                         last_point
);

	dlr_cmd_t    cmd;
	dlr_status_t status;

	// Sequencing
	dlr_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	// Arithmetic
	dlr_datapath #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.point_x    (point_x),
		.point_y    (point_y),
		.last_point (last_point)
	);

endmodule

### rtl/dlr_div.sv
// Iterative restoring divider: round(mag_d * 2^FRAC_BITS / steps), one bit per cycle.
module dlr_div import dlr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  start,
	input  logic                  step,
	input  logic [COORD_BITS-1:0] mag_d,
	input  logic [COORD_BITS-1:0] steps,
	output logic [FRAC_BITS:0]    quot
);

	// Numerator width: mag_d * 2^F plus half the divisor
	localparam int NW = COORD_BITS + FRAC_BITS + 1;

	logic [NW-1:0]         numer;
	logic [COORD_BITS-1:0] divisor_q;
	logic [COORD_BITS-1:0] rem_q;
	logic [FRAC_BITS:0]    low_q;
	logic [FRAC_BITS:0]    quot_q;
	logic [COORD_BITS:0]   trial;
	logic [COORD_BITS:0]   diff;
	logic                  qbit;

	// Rounded numerator: halves go away from zero
	assign numer = {1'b0, mag_d, {FRAC_BITS{1'b0}}}
		+ NW'({1'b0, steps[COORD_BITS-1:1]});

	// Trial subtraction for the next quotient bit
	assign trial = {rem_q, low_q[FRAC_BITS]};
	assign diff  = trial - {1'b0, divisor_q};
	assign qbit  = (trial >= {1'b0, divisor_q});

	// Quotient never exceeds 2^F, so the top part starts below the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			divisor_q <= steps;
			rem_q     <= numer[NW-1:FRAC_BITS+1];
			low_q     <= numer[FRAC_BITS:0];
			quot_q    <= '0;
		end else if (step) begin
			rem_q  <= qbit ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
			low_q  <= {low_q[FRAC_BITS-1:0], 1'b0};
			quot_q <= {quot_q[FRAC_BITS-1:0], qbit};
		end
	end

	assign quot = quot_q;

endmodule

### rtl/dlr_datapath.sv
// Datapath: endpoint set-up, increment dividers, accumulators and result register.
module dlr_datapath import dlr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dlr_cmd_t                     cmd,
	output dlr_status_t                  status,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	output logic signed [COORD_BITS-1:0] point_x,
	output logic signed [COORD_BITS-1:0] point_y,
	output logic                         last_point
);

	localparam int AW = COORD_BITS + FRAC_BITS + 2;  // accumulator width
	localparam int IW = FRAC_BITS + 2;               // increment width
	localparam int PW = COORD_BITS + 2;              // rounded point width
	localparam logic signed [AW-1:0] HALF = AW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [PW-1:0] P_HI = PW'((2 ** (COORD_BITS - 1)) - 1);
	localparam logic signed [PW-1:0] P_LO = -PW'(2 ** (COORD_BITS - 1));

	logic signed [COORD_BITS:0]   dx, dy;
	logic        [COORD_BITS-1:0] mag_x, mag_y, steps;
	logic        [FRAC_BITS:0]    quot_x, quot_y;
	logic signed [IW-1:0]         inc_x_q, inc_y_q;
	logic signed [AW-1:0]         acc_x_q, acc_y_q;
	logic signed [AW-1:0]         rnd_x, rnd_y;
	logic signed [PW-1:0]         pix_x, pix_y;
	logic                         neg_x_q, neg_y_q, zero_q;
	logic        [COORD_BITS:0]   points_left_q;
	logic                         line_active_q;
	logic                         last;

	// Deltas, magnitudes and major axis length
	assign dx    = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
	assign dy    = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
	assign mag_x = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
	assign mag_y = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
	assign steps = (mag_x > mag_y) ? mag_x : mag_y;

	// Increment dividers, one per axis
	dlr_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_x (
		.clk   (clk),
		.start (cmd.load),
		.step  (cmd.div_step),
		.mag_d (mag_x),
		.steps (steps),
		.quot  (quot_x)
	);

	dlr_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_y (
		.clk   (clk),
		.start (cmd.load),
		.step  (cmd.div_step),
		.mag_d (mag_y),
		.steps (steps),
		.quot  (quot_y)
	);

	// Rounding (halves up) and saturation to the coordinate range
	assign rnd_x = acc_x_q + HALF;
	assign rnd_y = acc_y_q + HALF;
	assign pix_x = rnd_x[AW-1:FRAC_BITS];
	assign pix_y = rnd_y[AW-1:FRAC_BITS];
	assign last  = (points_left_q <= (COORD_BITS+1)'(1));

	// Line set-up, increments, accumulators and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_x_q <= dx[COORD_BITS];
			neg_y_q <= dy[COORD_BITS];
			zero_q  <= (steps == '0);
			acc_x_q <= {{2{start_x[COORD_BITS-1]}}, start_x, {FRAC_BITS{1'b0}}};
			acc_y_q <= {{2{start_y[COORD_BITS-1]}}, start_y, {FRAC_BITS{1'b0}}};
		end else if (cmd.step) begin
			acc_x_q <= acc_x_q + {{(AW-IW){inc_x_q[IW-1]}}, inc_x_q};
			acc_y_q <= acc_y_q + {{(AW-IW){inc_y_q[IW-1]}}, inc_y_q};
		end
		if (cmd.finish) begin
			if (zero_q) begin
				inc_x_q <= '0;
				inc_y_q <= '0;
			end else begin
				inc_x_q <= neg_x_q ? -$signed({1'b0, quot_x}) : $signed({1'b0, quot_x});
				inc_y_q <= neg_y_q ? -$signed({1'b0, quot_y}) : $signed({1'b0, quot_y});
			end
		end
		if (cmd.step) begin
			point_x    <= (pix_x > P_HI) ? COORD_BITS'(P_HI) :
				(pix_x < P_LO) ? COORD_BITS'(P_LO) : pix_x[COORD_BITS-1:0];
			point_y    <= (pix_y > P_HI) ? COORD_BITS'(P_HI) :
				(pix_y < P_LO) ? COORD_BITS'(P_LO) : pix_y[COORD_BITS-1:0];
			last_point <= last;
		end
	end

	// Point count and active flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_left_q <= '0;
			line_active_q <= 1'b0;
		end else if (cmd.load) begin
			points_left_q <= {1'b0, steps} + (COORD_BITS+1)'(1);
			line_active_q <= 1'b1;
		end else if (cmd.step) begin
			if (last) begin
				points_left_q <= '0;
				line_active_q <= 1'b0;
			end else begin
				points_left_q <= points_left_q - (COORD_BITS+1)'(1);
			end
		end
	end

	assign status.line_active = line_active_q;

endmodule

### rtl/dlr_ctrl.sv
// Controller: transaction handshakes, division sequencing and result valid.
module dlr_ctrl import dlr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	output logic        out_valid,
	input  logic        out_stall,
	output dlr_cmd_t    cmd,
	input  dlr_status_t status
);

	localparam int CW = $clog2(FRAC_BITS + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t          state_q, state_d;
	logic [CW-1:0]   cnt_q;
	logic            out_valid_q;
	logic            accept;

	// Take a transaction only when idle and the result register can move
	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;

	// Commands
	always_comb begin
		cmd          = '0;
		cmd.load     = accept && (action == ACT_LOAD);
		cmd.step     = accept && (action == ACT_STEP) && status.line_active;
		cmd.div_step = (state_q == S_DIV);
		cmd.finish   = (state_q == S_FIN);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.load)
					state_d = S_DIV;
			end
			S_DIV: begin
				if (cnt_q == CW'(FRAC_BITS))
					state_d = S_FIN;
			end
			S_FIN: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// State, bit counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV)
				cnt_q <= cnt_q + CW'(1);
			else
				cnt_q <= '0;
			if (cmd.step)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the DDA line rasteriser: directed table, random lines, point checker.
module tb_top;
	import dlr_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int FB = FRAC_BITS_DEF;
	localparam int ITEMS = 1750;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = FB + 8;
	localparam int HOLD_CYCLES = 400;

	typedef logic signed [CB-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   is_last;
	} point_t;

	// How a table row is checked
	typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_POINT} row_check_t;

	typedef struct packed {
		logic       act;
		int         sx;
		int         sy;
		int         ex;
		int         ey;
		row_check_t chk;
		int         tx;
		int         ty;
		logic       tl;
	} row_t;

	// Directed stimulus; typed points where they are obvious, predictor elsewhere
	localparam row_t DIRECTED_ROWS [26] = '{
		'{ACT_STEP,     0,     0,     0,     0, CHK_NONE,      0,     0, 1'b0}, // no line yet
		'{ACT_LOAD,     5,     7,     5,     7, CHK_NONE,      0,     0, 1'b0}, // equal endpoints
		'{ACT_STEP,  2047, -2048,    -1,     1, CHK_POINT,     5,     7, 1'b1},
		'{ACT_STEP,     0,     0,     0,     0, CHK_NONE,      0,     0, 1'b0}, // line done
		'{ACT_LOAD, -2048, -2048,  2047,  2047, CHK_NONE,      0,     0, 1'b0}, // full diagonal
		'{ACT_STEP,     0,     0,     0,     0, CHK_POINT, -2048, -2048, 1'b0},
		'{ACT_STEP,    -1,    -1,    -1,    -1, CHK_POINT, -2047, -2047, 1'b0},
		'{ACT_LOAD,  2047, -2048, -2048,  2047, CHK_NONE,      0,     0, 1'b0}, // replaces line
		'{ACT_STEP,     0,     0,     0,     0, CHK_POINT,  2047, -2048, 1'b0},
		'{ACT_STEP,     0,     0,     0,     0, CHK_POINT,  2046, -2047, 1'b0},
		'{ACT_LOAD,     0,     0,     3,     1, CHK_PRED,      0,     0, 1'b0}, // shallow slope
		'{ACT_STEP,     0,     0,     0,     0, CHK_PRED,      0,     0, 1'b0},
		'{ACT_STEP,     0,     0,     0,     0, CHK_PRED,      0,     0, 1'b0},
		'{ACT_STEP,     0,     0,     0,     0, CHK_PRED,      0,     0, 1'b0},
		'{ACT_STEP,     0,     0,     0,     0, CHK_PRED,      0,     0, 1'b0},
		'{ACT_STEP,     0,     0,     0,     0, CHK_NONE,      0,     0, 1'b0},
		'{ACT_LOAD,     0,     0,    -1,    -2, CHK_PRED,      0,     0, 1'b0}, // negative halves
		'{ACT_STEP,     0,     0,     0,     0, CHK_PRED,      0,     0, 1'b0},
		'{ACT_STEP,     0,     0,     0,     0, CHK_PRED,      0,     0, 1'b0},
		'{ACT_STEP,     0,     0,     0,     0, CHK_PRED,      0,     0, 1'b0},
		'{ACT_LOAD,     0,     0,     1,     2, CHK_PRED,      0,     0, 1'b0}, // positive halves
		'{ACT_STEP,     0,     0,     0,     0, CHK_PRED,      0,     0, 1'b0},
		'{ACT_STEP,     0,     0,     0,     0, CHK_PRED,      0,     0, 1'b0},
		'{ACT_STEP,     0,     0,     0,     0, CHK_PRED,      0,     0, 1'b0},
		'{ACT_LOAD, -2048,  2047, -2048,  2047, CHK_NONE,      0,     0, 1'b0}, // single point corner
		'{ACT_STEP,  2047,  2047,  2047,  2047, CHK_POINT, -2048,  2047, 1'b1}
	};

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_stall;
	logic   action = ACT_LOAD;
	coord_t start_x = '0;
	coord_t start_y = '0;
	coord_t end_x = '0;
	coord_t end_y = '0;
	logic   out_valid;
	logic   out_stall = 1'b0;
	coord_t point_x;
	coord_t point_y;
	logic   last_point;

	point_t pending_points[$];
	int     mismatch_count = 0;
	int     results_seen = 0;
	int     items_done = 0;
	int     burst_left = 0;
	int     cycles = 0;

	// Predictor state: positions and slopes in fixed point
	longint x_pos_fx = 0;
	longint y_pos_fx = 0;
	longint x_slope_fx = 0;
	longint y_slope_fx = 0;
	longint pts_to_go = 0;
	bit     line_live = 1'b0;

	dda_line_rasterizer #(
		.COORD_BITS(CB),
		.FRAC_BITS (FB)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.point_x   (point_x),
		.point_y   (point_y),
		.last_point(last_point)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		mismatch_count++;
	endtask

	// Slope magnitude |d|/steps rounded half away from zero, then signed
	function automatic longint slope_of(input longint d, input longint steps);
		longint n;
		longint q;
		if (steps == 0)
			return 0;
		n = (d < 0 ? -d : d) * (longint'(1) << FB);
		q = (n + steps / 2) / steps;
		return d < 0 ? -q : q;
	endfunction

	// Floor of position plus one half, saturated to the coordinate range
	function automatic coord_t pixel_of(input longint pos);
		longint p;
		p = (pos + (longint'(1) << (FB - 1))) >>> FB;
		if (p < -(longint'(1) << (CB - 1)))
			p = -(longint'(1) << (CB - 1));
		if (p > (longint'(1) << (CB - 1)) - 1)
			p = (longint'(1) << (CB - 1)) - 1;
		return coord_t'(p);
	endfunction

	// Predicts the point, if any, that one accepted transaction yields
	function automatic void rasterise_item(input logic act, input coord_t sx, input coord_t sy,
		input coord_t ex, input coord_t ey, output bit gave, output point_t pt);
		longint dx;
		longint dy;
		longint adx;
		longint ady;
		longint steps;
		gave = 1'b0;
		pt = '0;
		if (act == ACT_LOAD) begin
			dx = longint'(ex) - longint'(sx);
			dy = longint'(ey) - longint'(sy);
			adx = dx < 0 ? -dx : dx;
			ady = dy < 0 ? -dy : dy;
			steps = adx > ady ? adx : ady;
			x_slope_fx = slope_of(dx, steps);
			y_slope_fx = slope_of(dy, steps);
			x_pos_fx = longint'(sx) * (longint'(1) << FB);
			y_pos_fx = longint'(sy) * (longint'(1) << FB);
			pts_to_go = steps + 1;
			line_live = 1'b1;
		end else if (line_live) begin
			gave = 1'b1;
			pt.x = pixel_of(x_pos_fx);
			pt.y = pixel_of(y_pos_fx);
			pt.is_last = pts_to_go <= 1;
			if (pts_to_go <= 1) begin
				pts_to_go = 0;
				line_live = 1'b0;
			end else begin
				pts_to_go--;
			end
			x_pos_fx += x_slope_fx;
			y_pos_fx += y_slope_fx;
		end
	endfunction

	// Sender bursts: random gap between bursts, now and then a long unbroken run
	task automatic pace();
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 20);
		end
		burst_left--;
	endtask

	// Offer one transaction, wait for acceptance, queue what it should produce
	task automatic issue(input logic act, input coord_t sx, input coord_t sy, input coord_t ex,
		input coord_t ey, input row_check_t chk, input point_t typed_pt, output bit counted);
		bit     gave;
		point_t pt;
		in_valid <= 1'b1;
		action <= act;
		start_x <= sx;
		start_y <= sy;
		end_x <= ex;
		end_y <= ey;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		rasterise_item(act, sx, sy, ex, ey, gave, pt);
		case (chk)
			CHK_PRED: if (gave) pending_points.push_back(pt);
			CHK_POINT: pending_points.push_back(typed_pt);
			default: ;
		endcase
		counted = (act == ACT_LOAD) || gave;
	endtask

	// Endpoint offset from c, mirrored if it would leave the range
	function automatic coord_t offset_coord(input coord_t c, input int d);
		int e;
		e = int'(c) + d;
		if (e > (1 << (CB - 1)) - 1 || e < -(1 << (CB - 1)))
			e = int'(c) - d;
		return coord_t'(e);
	endfunction

	// One random line: load, then mostly a full walk, sometimes cut short or overrun
	task automatic random_line();
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
		int     shape;
		int     span;
		int     dx;
		int     dy;
		int     adx;
		int     ady;
		int     pts;
		int     n;
		int     r;
		bit     counted;
		shape = $urandom_range(0, 99);
		sx = coord_t'($urandom);
		sy = coord_t'($urandom);
		if (shape >= 85 && shape < 93) begin
			ex = coord_t'($urandom);
			ey = coord_t'($urandom);
		end else begin
			span = (shape >= 65 && shape < 85) ? 60 : 10;
			dx = int'($urandom_range(0, 2 * span)) - span;
			dy = int'($urandom_range(0, 2 * span)) - span;
			if (shape >= 93) begin
				case ($urandom_range(0, 3))
					0: dx = 0;
					1: dy = 0;
					2: dy = $urandom_range(0, 1) ? dx : -dx;
					default: begin
						dx = 0;
						dy = 0;
					end
				endcase
			end
			ex = offset_coord(sx, dx);
			ey = offset_coord(sy, dy);
		end
		adx = int'(ex) - int'(sx);
		ady = int'(ey) - int'(sy);
		adx = adx < 0 ? -adx : adx;
		ady = ady < 0 ? -ady : ady;
		pts = (adx > ady ? adx : ady) + 1;
		r = $urandom_range(0, 9);
		if (r < 7)
			n = pts;
		else if (r < 8)
			n = pts + $urandom_range(1, 3);
		else
			n = $urandom_range(0, pts - 1);
		if (n > 80)
			n = $urandom_range(1, 80);
		pace();
		issue(ACT_LOAD, sx, sy, ex, ey, CHK_PRED, '0, counted);
		items_done += counted;
		repeat (n) begin
			pace();
			issue(ACT_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
				coord_t'($urandom), CHK_PRED, '0, counted);
			items_done += counted;
		end
	endtask

	// Receiver stall patterns, plus one long hold-off to back the block up
	initial begin : receiver
		int  mode;
		int  k;
		bit  held;
		held = 1'b0;
		k = 0;
		@(posedge arst_n);
		forever begin
			if (!held && results_seen >= 300) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 3);
				repeat ($urandom_range(20, 200)) begin
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= ($urandom_range(0, 3) == 0);
						2: out_stall <= ($urandom_range(0, 3) != 0);
						default: out_stall <= (k % 7) < 3;
					endcase
					k++;
					@(posedge clk);
				end
			end
		end
	end

	// Point checker
	always @(posedge clk) begin : point_check
		point_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			results_seen++;
			if (pending_points.size() == 0) begin
				report_mismatch($sformatf("unexpected point (%0d, %0d)", point_x, point_y));
			end else begin
				want = pending_points.pop_front();
				if (point_x !== want.x)
					report_mismatch($sformatf("point_x %0d, wanted %0d", point_x, want.x));
				if (point_y !== want.y)
					report_mismatch($sformatf("point_y %0d, wanted %0d", point_y, want.y));
				if (last_point !== want.is_last)
					report_mismatch($sformatf("last_point %b, wanted %b", last_point,
						want.is_last));
			end
		end
	end

	// Main stimulus
	initial begin : stimulus
		row_t   r;
		point_t typed_pt;
		bit     counted;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
			r = DIRECTED_ROWS[i];
			typed_pt.x = coord_t'(r.tx);
			typed_pt.y = coord_t'(r.ty);
			typed_pt.is_last = r.tl;
			pace();
			issue(r.act, coord_t'(r.sx), coord_t'(r.sy), coord_t'(r.ex), coord_t'(r.ey),
				r.chk, typed_pt, counted);
		end

		while (items_done < ITEMS)
			random_line();
		in_valid <= 1'b0;

		while (pending_points.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
